/* sv/pbldb_pkg.sv */
// Shared types, constants and the Q16 threshold table of the block level dB meter.
package pbldb_pkg;

  // Search covers 0..DB_TOP dB of ratio between the larger and smaller operand
  localparam int unsigned KW = 7;
  localparam logic [KW-1:0] DB_TOP = 7'd96;

  // Thresholds repeat every decade of 20 dB, scaled by ten
  localparam int unsigned RW = 5;
  localparam logic [RW-1:0] RES_LAST = 5'd19;
  localparam int unsigned BW = 20;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_SETUP,
    ST_MUL,
    ST_CMP,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic acc;    // add the transferred sample into the block sum
    logic setup;  // snapshot sum and count, clear them, start search
    logic mul;    // form scaled threshold product
    logic step;   // advance to the next dB step
    logic fin;    // latch the final level
    logic push;   // move the level into the output register
  } cmd_t;

  typedef struct packed {
    logic zero;      // silent block or empty count
    logic hit;       // big * 2^16 below product: level found
    logic k_top;     // search at its last step
    logic out_free;  // output register can take a result this cycle
  } status_t;

  // round(65536 * 10^(r/20)), r = 0..19
  function automatic logic [BW-1:0] thr_base(input logic [RW-1:0] r);
    logic [BW-1:0] t;
    case (r)
      5'd0:    t = 20'd65536;
      5'd1:    t = 20'd73533;
      5'd2:    t = 20'd82505;
      5'd3:    t = 20'd92572;
      5'd4:    t = 20'd103868;
      5'd5:    t = 20'd116541;
      5'd6:    t = 20'd130762;
      5'd7:    t = 20'd146717;
      5'd8:    t = 20'd164619;
      5'd9:    t = 20'd184706;
      5'd10:   t = 20'd207243;
      5'd11:   t = 20'd232531;
      5'd12:   t = 20'd260904;
      5'd13:   t = 20'd292739;
      5'd14:   t = 20'd328458;
      5'd15:   t = 20'd368536;
      5'd16:   t = 20'd413504;
      5'd17:   t = 20'd463959;
      5'd18:   t = 20'd520571;
      5'd19:   t = 20'd584090;
      default: t = 20'd65536;
    endcase
    return t;
  endfunction

endpackage

/* sv/pcm_block_level_db_meter_core.sv */
// Top level of the PCM block level dB meter: controller plus datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o | sample_i (s16), last_i
//   out     | output    | out_valid_o / out_ready_i | level_db_o (s8)
//
// A sample without last transfers and is summed at once.
// A sample with last holds input ready low for a setup state, then a registered
// threshold multiply and a compare per dB step, and a load state; a silent block
// skips the compare. The level found is at most DB_TOP (96) dB in magnitude.
// The result sits in an output register; a stalled receiver holds the load
// cycle, after which new samples transfer while the result waits to be taken.
// Asynchronous active-low reset clears sum, count, state and output valid.
module pcm_block_level_db_meter_core #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [7:0]  level_db_o
);
  import pbldb_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Sequence accumulate, search and delivery
  pbldb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the block sum and count, run the threshold compare, drive the result
  pbldb_dp #(
    .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .level_db_o  (level_db_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* sv/pbldb_ctrl.sv */
// Controller state machine of the block level dB meter: accumulate, search, deliver.
module pbldb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_ready_o,
  input  pbldb_pkg::status_t sts_i,
  output pbldb_pkg::cmd_t   cmd_o
);
  import pbldb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC: begin
        if (in_valid_i && last_i) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = ST_MUL;
      ST_MUL: begin
        state_d = sts_i.zero ? ST_WAIT : ST_CMP;
      end
      ST_CMP: begin
        state_d = (sts_i.hit || sts_i.k_top) ? ST_WAIT : ST_MUL;
      end
      ST_WAIT: begin
        if (sts_i.out_free) state_d = ST_ACC;
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACC: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
      end
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_MUL: begin
        cmd_o.fin = sts_i.zero;
        cmd_o.mul = !sts_i.zero;
      end
      ST_CMP: begin
        cmd_o.fin  = sts_i.hit || sts_i.k_top;
        cmd_o.step = !(sts_i.hit || sts_i.k_top);
      end
      ST_WAIT: cmd_o.push = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* sv/pbldb_dp.sv */
// Datapath of the block level dB meter: sum and count, threshold search, output register.
module pbldb_dp #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] sample_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [7:0]  level_db_o,
  input  pbldb_pkg::cmd_t    cmd_i,
  output pbldb_pkg::status_t sts_o
);
  import pbldb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SumW = CntW + 15;
  localparam int unsigned ScW  = CntW + 14;  // count times up to 10^4
  localparam int unsigned PrW  = ScW + BW;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCK_SAMPLES);

  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] big_q;
  logic [ScW-1:0]  sc_q;
  logic [PrW-1:0]  prod_q;
  logic [KW-1:0]   k_q;
  logic [RW-1:0]   r_q;
  logic            neg_q;
  logic            zero_q;
  logic signed [7:0] lvl_q;

  logic [15:0]     mag;
  logic            s_ge_c;
  logic [CntW-1:0] small_v;
  logic [KW-1:0]   lvl_mag;

  assign mag     = sample_i[15] ? 16'(~sample_i + 16'sd1) : 16'(sample_i);
  assign s_ge_c  = sum_q >= SumW'(cnt_q);
  // When the sum is below the count it is narrower than the count
  assign small_v = s_ge_c ? cnt_q : sum_q[CntW-1:0];

  // Accumulator and count; clear on snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.acc && (cnt_q < CntMax)) begin
      sum_q <= sum_q + SumW'(mag);
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Search registers: big/small operand, scaled small, step index
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      big_q  <= s_ge_c ? sum_q : SumW'(cnt_q);
      sc_q   <= ScW'(small_v);
      neg_q  <= !s_ge_c;
      zero_q <= (sum_q == '0) || (cnt_q == '0);
      k_q    <= KW'(1);
      r_q    <= RW'(1);
    end else if (cmd_i.step) begin
      k_q <= k_q + 1'b1;
      if (r_q == RES_LAST) begin
        r_q  <= '0;
        sc_q <= ScW'({sc_q, 3'b000} + {sc_q, 1'b0});
      end else begin
        r_q <= r_q + 1'b1;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= PrW'(sc_q) * PrW'(thr_base(r_q));
    end
    if (cmd_i.fin) begin
      lvl_q <= zero_q ? 8'sd0 : (neg_q ? -$signed({1'b0, lvl_mag}) : $signed({1'b0, lvl_mag}));
    end
  end

  // Compare big * 2^16 against small * T[k]
  always_comb begin
    sts_o.zero  = zero_q;
    sts_o.hit   = (PrW'({big_q, 16'd0})) < prod_q;
    sts_o.k_top = k_q == DB_TOP;
    sts_o.out_free = !out_valid_o || out_ready_i;
    lvl_mag     = sts_o.hit ? k_q - 1'b1 : k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) level_db_o <= lvl_q;
  end

endmodule
